@@ hw/rtl/wdm_pkg.sv @@
// Package of shared types and constants for the drift monitor.
package wdm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DIST_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MUL_A_W    = SAMPLE_W + 1;

    localparam int DEF_BASE_DEPTH   = 256;
    localparam int DEF_RECENT_DEPTH = 64;

    localparam int RST_BASE_LEN   = 256;
    localparam int RST_RECENT_LEN = 64;
    localparam logic [15:0] RST_THRESHOLD = 16'd256;
    localparam logic [8:0]  RST_FRACTION  = 9'd128;
    localparam logic [8:0]  MAX_FRACTION  = 9'd256;
    localparam logic [15:0] DIST_SAT      = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECENT_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION   = 2'd3;

    typedef enum logic [2:0] {
        T_IDLE,
        T_WIN,
        T_DIST,
        T_FLAG,
        T_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        W_IDLE,
        W_RING,
        W_READ,
        W_MERGE,
        W_TAIL
    } t_win_state;

    typedef enum logic [3:0] {
        D_IDLE,
        D_FETCH,
        D_MUL_A,
        D_MUL_B,
        D_MUL_C,
        D_SUB,
        D_ACC,
        D_NORM,
        D_SCALE,
        D_SCALE2,
        D_DIV,
        D_DONE
    } t_dist_state;

endpackage

@@ hw/rtl/wdm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/wdm_window.sv @@
// One sample window: ring store plus a sorted copy kept up to date by a merge pass.
module wdm_window #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH),
    localparam int FW = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [FW-1:0]                 i_length,
    input  logic                          i_start,
    input  logic [wdm_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_done,
    output logic [FW-1:0]                 o_fill,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_idx,
    output logic [wdm_pkg::SAMPLE_W-1:0]  o_rd_data
);
    import wdm_pkg::*;

    t_win_state          r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [FW-1:0]       r_fill, n_fill;
    logic                r_bank, n_bank;
    logic [FW-1:0]       r_k, n_k;
    logic [FW-1:0]       r_o, n_o;
    logic                r_ins, n_ins;
    logic                r_rem, n_rem;
    logic                r_evict, n_evict;
    logic [SAMPLE_W-1:0] r_old, n_old;
    logic [SAMPLE_W-1:0] r_x, n_x;

    logic                ring_re, ring_we;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic                srt_re, srt_we;
    logic [AW:0]         srt_raddr, srt_waddr;
    logic [SAMPLE_W-1:0] srt_wdata, srt_rdata;

    wdm_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_head),
        .i_wdata (r_x),
        .i_re    (ring_re),
        .i_raddr (r_head),
        .o_rdata (ring_rdata)
    );

    // Two banks: the merge reads the current bank and writes the other.
    wdm_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 * DEPTH)) u_sorted (
        .i_clk   (i_clk),
        .i_we    (srt_we),
        .i_waddr (srt_waddr),
        .i_wdata (srt_wdata),
        .i_re    (srt_re),
        .i_raddr (srt_raddr),
        .o_rdata (srt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state <= W_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_bank  <= n_bank;
        end
        r_k     <= n_k;
        r_o     <= n_o;
        r_ins   <= n_ins;
        r_rem   <= n_rem;
        r_evict <= n_evict;
        r_old   <= n_old;
        r_x     <= n_x;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_fill    = r_fill;
        n_bank    = r_bank;
        n_k       = r_k;
        n_o       = r_o;
        n_ins     = r_ins;
        n_rem     = r_rem;
        n_evict   = r_evict;
        n_old     = r_old;
        n_x       = r_x;
        ring_re   = 1'b0;
        ring_we   = 1'b0;
        srt_re    = 1'b0;
        srt_we    = 1'b0;
        srt_raddr = {r_bank, r_k[AW-1:0]};
        srt_waddr = {~r_bank, r_o[AW-1:0]};
        srt_wdata = r_x;
        o_done    = 1'b0;
        unique case (r_state)
            W_IDLE: begin
                srt_raddr = {r_bank, i_rd_idx};
                srt_re    = i_rd_en;
                if (i_start) begin
                    ring_re = 1'b1;
                    n_x     = i_sample;
                    n_state = W_RING;
                end
            end
            W_RING: begin
                // The entry about to be overwritten leaves the window when it is full.
                ring_we = 1'b1;
                n_old   = ring_rdata;
                n_evict = (r_fill == i_length);
                n_k     = '0;
                n_o     = '0;
                n_ins   = 1'b0;
                n_rem   = 1'b0;
                n_state = W_READ;
            end
            W_READ: begin
                if (r_k == r_fill) begin
                    n_state = W_TAIL;
                end else begin
                    srt_re  = 1'b1;
                    n_state = W_MERGE;
                end
            end
            W_MERGE: begin
                srt_we = 1'b1;
                if (r_evict && !r_rem && srt_rdata == r_old) begin
                    srt_we  = 1'b0;
                    n_rem   = 1'b1;
                    n_k     = r_k + 1'b1;
                    n_state = W_READ;
                end else if (!r_ins && $signed(r_x) <= $signed(srt_rdata)) begin
                    n_ins = 1'b1;
                    n_o   = r_o + 1'b1;
                end else begin
                    srt_wdata = srt_rdata;
                    n_o       = r_o + 1'b1;
                    n_k       = r_k + 1'b1;
                    n_state   = W_READ;
                end
            end
            W_TAIL: begin
                srt_we  = !r_ins;
                n_bank  = ~r_bank;
                n_head  = (FW'(r_head) == i_length - 1'b1) ? '0 : r_head + 1'b1;
                if (r_fill < i_length) begin
                    n_fill = r_fill + 1'b1;
                end
                o_done  = 1'b1;
                n_state = W_IDLE;
            end
            default: n_state = W_IDLE;
        endcase
    end

    assign o_fill    = r_fill;
    assign o_rd_data = srt_rdata;

endmodule

@@ hw/rtl/wdm_dist.sv @@
// Distance sequencer: one shared multiplier for the interpolated terms and the scale factor, then a bit-serial divide.
module wdm_dist #(
    parameter int BASE_DEPTH   = 256,
    parameter int RECENT_DEPTH = 64,
    localparam int BAW = $clog2(BASE_DEPTH),
    localparam int RAW = $clog2(RECENT_DEPTH),
    localparam int BFW = $clog2(BASE_DEPTH + 1),
    localparam int RFW = $clog2(RECENT_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [BFW-1:0]               i_n,
    input  logic [RFW-1:0]               i_m,
    output logic                         o_base_re,
    output logic [BAW-1:0]               o_base_idx,
    input  logic [wdm_pkg::SAMPLE_W-1:0] i_base_data,
    output logic                         o_recent_re,
    output logic [RAW-1:0]               o_recent_idx,
    input  logic [wdm_pkg::SAMPLE_W-1:0] i_recent_data,
    output logic                         o_done,
    output logic [wdm_pkg::DIST_W-1:0]   o_distance
);
    import wdm_pkg::*;

    localparam int DBW = BAW;
    localparam int PW  = MUL_A_W + DBW + 1;
    localparam int ACW = PW + 1;
    localparam int SW  = SAMPLE_W + 2 * DBW + 2;
    localparam int VW  = 2 * DBW + 1;
    localparam int CW  = $clog2(SW + 1);
    localparam int RW  = $clog2(BASE_DEPTH + RECENT_DEPTH);

    t_dist_state          r_state, n_state;
    logic [DBW-1:0]       r_d, n_d;
    logic [RAW-1:0]       r_mm1, n_mm1;
    logic [BAW-1:0]       r_i, n_i;
    logic [RAW-1:0]       r_j, n_j;
    logic [RW-1:0]        r_r, n_r;
    logic [SAMPLE_W-1:0]  r_bj, n_bj;
    logic signed [PW-1:0] r_prod;
    logic signed [ACW-1:0] r_acc, n_acc;
    logic [SW-1:0]        r_sum, n_sum;
    logic [VW-1:0]        r_div, n_div;
    logic [VW-1:0]        r_rem, n_rem;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [DIST_W-1:0]    r_dist, n_dist;

    logic signed [MUL_A_W-1:0] mul_a;
    logic [DBW-1:0]            mul_b;
    logic [ACW-1:0]            acc_abs;
    logic [VW:0]               trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_prod <= mul_a * $signed({1'b0, mul_b});
        r_d    <= n_d;
        r_mm1  <= n_mm1;
        r_i    <= n_i;
        r_j    <= n_j;
        r_r    <= n_r;
        r_bj   <= n_bj;
        r_acc  <= n_acc;
        r_sum  <= n_sum;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_dist <= n_dist;
    end

    assign acc_abs = r_acc[ACW-1] ? ACW'(-r_acc) : ACW'(r_acc);
    assign trial   = {r_rem, r_sum[SW-1]};

    always_comb begin
        n_state      = r_state;
        n_d          = r_d;
        n_mm1        = r_mm1;
        n_i          = r_i;
        n_j          = r_j;
        n_r          = r_r;
        n_bj         = r_bj;
        n_acc        = r_acc;
        n_sum        = r_sum;
        n_div        = r_div;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_dist       = r_dist;
        mul_a        = '0;
        mul_b        = '0;
        o_base_re    = 1'b0;
        o_base_idx   = r_i;
        o_recent_re  = 1'b0;
        o_recent_idx = r_j;
        o_done       = 1'b0;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_d     = DBW'(i_n - 1'b1);
                    n_mm1   = RAW'(i_m - 1'b1);
                    n_i     = '0;
                    n_j     = '0;
                    n_r     = '0;
                    n_sum   = '0;
                    n_state = D_FETCH;
                end
            end
            D_FETCH: begin
                o_base_re   = 1'b1;
                o_recent_re = 1'b1;
                n_state     = D_MUL_A;
            end
            D_MUL_A: begin
                mul_a        = {i_base_data[SAMPLE_W-1], i_base_data};
                mul_b        = r_d;
                n_bj         = i_recent_data;
                o_recent_re  = (r_r != '0);
                o_recent_idx = r_j + 1'b1;
                n_state      = D_MUL_B;
            end
            D_MUL_B: begin
                n_acc   = ACW'(r_prod);
                mul_a   = {r_bj[SAMPLE_W-1], r_bj};
                mul_b   = r_d - DBW'(r_r);
                n_state = D_MUL_C;
            end
            D_MUL_C: begin
                n_acc = r_acc - ACW'(r_prod);
                if (r_r != '0) begin
                    mul_a = {i_recent_data[SAMPLE_W-1], i_recent_data};
                end
                mul_b   = DBW'(r_r);
                n_state = D_SUB;
            end
            D_SUB: begin
                n_acc   = r_acc - ACW'(r_prod);
                n_state = D_ACC;
            end
            D_ACC: begin
                n_sum = r_sum + SW'(acc_abs);
                if (BFW'(r_i) == BFW'(r_d)) begin
                    n_state = D_SCALE;
                end else begin
                    n_r     = r_r + RW'(r_mm1);
                    n_state = D_NORM;
                end
            end
            D_NORM: begin
                // Bring the interpolation remainder back below n - 1, one step a cycle.
                if (r_r >= RW'(r_d)) begin
                    n_r = r_r - RW'(r_d);
                    n_j = r_j + 1'b1;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = D_FETCH;
                end
            end
            D_SCALE: begin
                mul_a   = MUL_A_W'(r_d) + 1'b1;
                mul_b   = r_d;
                n_state = D_SCALE2;
            end
            D_SCALE2: begin
                n_div   = VW'(r_prod);
                n_rem   = '0;
                n_cnt   = CW'(SW);
                n_state = D_DIV;
            end
            D_DIV: begin
                if (trial >= {1'b0, r_div}) begin
                    n_rem = VW'(trial - {1'b0, r_div});
                    n_sum = {r_sum[SW-2:0], 1'b1};
                end else begin
                    n_rem = trial[VW-1:0];
                    n_sum = {r_sum[SW-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = D_DONE;
                end
            end
            D_DONE: begin
                n_dist  = (|r_sum[SW-1:DIST_W]) ? DIST_SAT : r_sum[DIST_W-1:0];
                o_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    assign o_distance = n_dist;

endmodule

@@ hw/rtl/wasserstein_drift_monitor_unit.sv @@
// Top level of the Wasserstein-1 drift monitor: registers, sequencing, flag and counters.
//
//  Channel   Direction  Handshake              Payload
//  input     in         i_valid / o_stall      i_sample
//  result    out        o_valid / i_stall      o_distance .. o_sample_total
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Each window first runs a merge pass over its sorted copy, both windows in parallel;
// when both are filled enough, the distance sequencer steps through the baseline entries
// and recent steps on its shared multiplier, then runs a bit-serial division producing
// SW quotient bits. Reset is synchronous and active low; stores are not cleared.
// o_stall is high from acceptance until the result has been taken.
module wasserstein_drift_monitor_unit #(
    parameter int BASE_DEPTH   = wdm_pkg::DEF_BASE_DEPTH,
    parameter int RECENT_DEPTH = wdm_pkg::DEF_RECENT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [wdm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [wdm_pkg::DIST_W-1:0]     o_distance,
    output logic                           o_distance_valid,
    output logic                           o_drifting,
    output logic                           o_drift_began,
    output logic                           o_drift_ended,
    output logic [wdm_pkg::COUNT_W-1:0]    o_event_total,
    output logic [wdm_pkg::COUNT_W-1:0]    o_sample_total,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wdm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wdm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wdm_pkg::*;

    localparam int BAW = $clog2(BASE_DEPTH);
    localparam int RAW = $clog2(RECENT_DEPTH);
    localparam int BFW = $clog2(BASE_DEPTH + 1);
    localparam int RFW = $clog2(RECENT_DEPTH + 1);
    localparam int BASE_RST   = (RST_BASE_LEN > BASE_DEPTH) ? BASE_DEPTH : RST_BASE_LEN;
    localparam int RECENT_RST = (RST_RECENT_LEN > RECENT_DEPTH) ? RECENT_DEPTH : RST_RECENT_LEN;

    t_top_state         r_state, n_state;
    logic [BFW-1:0]     r_blen;
    logic [RFW-1:0]     r_rlen;
    logic [15:0]        r_thr;
    logic [8:0]         r_frac;
    logic               r_flag, n_flag;
    logic [COUNT_W-1:0] r_onsets, n_onsets;
    logic [COUNT_W-1:0] r_records, n_records;
    logic               r_bdone, n_bdone;
    logic               r_rdone, n_rdone;
    logic               r_dvalid, n_dvalid;
    logic [DIST_W-1:0]  r_dist, n_dist;
    logic               r_began, n_began;
    logic               r_ended, n_ended;

    logic               cfg_we, len_clear;
    logic [15:0]        cfg_len;
    logic               win_start, dist_start;
    logic               base_done, recent_done, dist_done;
    logic [BFW-1:0]     base_fill;
    logic [RFW-1:0]     recent_fill;
    logic               base_re, recent_re;
    logic [BAW-1:0]     base_idx;
    logic [RAW-1:0]     recent_idx;
    logic [SAMPLE_W-1:0] base_data, recent_data;
    logic [DIST_W-1:0]  dist_value;
    logic [24:0]        clear_level;
    logic [24:0]        dist_scaled;
    logic               windows_ready;

    // Configuration is taken only between items, and never in the same cycle as an
    // input item, since a length write restarts the run.
    assign o_cfg_ready = (r_state == T_IDLE) && !i_valid;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign len_clear   = cfg_we && (i_cfg_index == REG_BASE_LEN ||
                                    i_cfg_index == REG_RECENT_LEN);

    always_comb begin
        if (i_cfg_index == REG_BASE_LEN) begin
            cfg_len = {7'd0, i_cfg_data[8:0]};
            if (cfg_len < 16'd4) begin
                cfg_len = 16'd4;
            end else if (cfg_len > 16'(BASE_DEPTH)) begin
                cfg_len = 16'(BASE_DEPTH);
            end
        end else begin
            cfg_len = {9'd0, i_cfg_data[6:0]};
            if (cfg_len < 16'd2) begin
                cfg_len = 16'd2;
            end else if (cfg_len > 16'(RECENT_DEPTH)) begin
                cfg_len = 16'(RECENT_DEPTH);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blen <= BFW'(BASE_RST);
            r_rlen <= RFW'(RECENT_RST);
            r_thr  <= RST_THRESHOLD;
            r_frac <= RST_FRACTION;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_BASE_LEN:   r_blen <= BFW'(cfg_len);
                REG_RECENT_LEN: r_rlen <= RFW'(cfg_len);
                REG_THRESHOLD:  r_thr  <= i_cfg_data;
                REG_FRACTION:   r_frac <= (i_cfg_data[8:0] > MAX_FRACTION) ?
                                          MAX_FRACTION : i_cfg_data[8:0];
                default:        r_thr  <= r_thr;
            endcase
        end
    end

    wdm_window #(.DEPTH(BASE_DEPTH)) u_base (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (len_clear),
        .i_length  (r_blen),
        .i_start   (win_start),
        .i_sample  (i_sample),
        .o_done    (base_done),
        .o_fill    (base_fill),
        .i_rd_en   (base_re),
        .i_rd_idx  (base_idx),
        .o_rd_data (base_data)
    );

    wdm_window #(.DEPTH(RECENT_DEPTH)) u_recent (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (len_clear),
        .i_length  (r_rlen),
        .i_start   (win_start),
        .i_sample  (i_sample),
        .o_done    (recent_done),
        .o_fill    (recent_fill),
        .i_rd_en   (recent_re),
        .i_rd_idx  (recent_idx),
        .o_rd_data (recent_data)
    );

    wdm_dist #(.BASE_DEPTH(BASE_DEPTH), .RECENT_DEPTH(RECENT_DEPTH)) u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (dist_start),
        .i_n           (base_fill),
        .i_m           (recent_fill),
        .o_base_re     (base_re),
        .o_base_idx    (base_idx),
        .i_base_data   (base_data),
        .o_recent_re   (recent_re),
        .o_recent_idx  (recent_idx),
        .i_recent_data (recent_data),
        .o_done        (dist_done),
        .o_distance    (dist_value)
    );

    // Hysteresis release test: W1 * 256 against threshold times the Q1.8 fraction.
    assign clear_level   = r_thr * r_frac;
    assign dist_scaled   = {1'b0, r_dist, 8'd0};
    assign windows_ready = (base_fill >= (r_blen >> 1)) && (recent_fill >= r_rlen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || len_clear) begin
            r_state   <= T_IDLE;
            r_flag    <= 1'b0;
            r_onsets  <= '0;
            r_records <= '0;
        end else begin
            r_state   <= n_state;
            r_flag    <= n_flag;
            r_onsets  <= n_onsets;
            r_records <= n_records;
        end
        r_bdone  <= n_bdone;
        r_rdone  <= n_rdone;
        r_dvalid <= n_dvalid;
        r_dist   <= n_dist;
        r_began  <= n_began;
        r_ended  <= n_ended;
    end

    always_comb begin
        n_state    = r_state;
        n_flag     = r_flag;
        n_onsets   = r_onsets;
        n_records  = r_records;
        n_bdone    = r_bdone || base_done;
        n_rdone    = r_rdone || recent_done;
        n_dvalid   = r_dvalid;
        n_dist     = r_dist;
        n_began    = r_began;
        n_ended    = r_ended;
        win_start  = 1'b0;
        dist_start = 1'b0;
        unique case (r_state)
            T_IDLE: begin
                if (i_valid) begin
                    win_start = 1'b1;
                    n_bdone   = 1'b0;
                    n_rdone   = 1'b0;
                    n_state   = T_WIN;
                end
            end
            T_WIN: begin
                if (r_bdone && r_rdone) begin
                    n_dvalid = windows_ready;
                    n_dist   = '0;
                    if (windows_ready) begin
                        dist_start = 1'b1;
                        n_state    = T_DIST;
                    end else begin
                        n_state = T_FLAG;
                    end
                end
            end
            T_DIST: begin
                if (dist_done) begin
                    n_dist  = dist_value;
                    n_state = T_FLAG;
                end
            end
            T_FLAG: begin
                n_began   = 1'b0;
                n_ended   = 1'b0;
                n_records = r_records + 1'b1;
                if (r_dvalid) begin
                    if (!r_flag && r_dist > r_thr) begin
                        n_flag   = 1'b1;
                        n_onsets = r_onsets + 1'b1;
                        n_began  = 1'b1;
                    end else if (r_flag && dist_scaled < clear_level) begin
                        n_flag  = 1'b0;
                        n_ended = 1'b1;
                    end
                end
                n_state = T_OUT;
            end
            T_OUT: begin
                if (!i_stall) begin
                    n_state = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    assign o_stall          = (r_state != T_IDLE);
    assign o_valid          = (r_state == T_OUT);
    assign o_distance       = r_dist;
    assign o_distance_valid = r_dvalid;
    assign o_drifting       = r_flag;
    assign o_drift_began    = r_began;
    assign o_drift_ended    = r_ended;
    assign o_event_total    = r_onsets;
    assign o_sample_total   = r_records;

    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_distance_valid || o_distance == '0))
        else $error("distance reported without both windows filled");

    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_drift_began && o_drift_ended))
        else $error("drift onset and end in one result");

    a_began_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drift_began) |-> o_drifting)
        else $error("drift onset without drift flag");

    a_dist_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_start |=> (r_state == T_DIST))
        else $error("distance started outside its phase");

endmodule
